>>> src/ias_pkg.sv
// ----------------------------------------------------------------------------
// ias_pkg - shared types for the insertion sorter
// Holds the data width, the controller state type and the control bundle
// that the controller broadcasts to the row of cells.
// ----------------------------------------------------------------------------
package ias_pkg;

    localparam int DataW = 32;

    typedef logic signed [DataW-1:0] data_t;

    typedef enum logic [0:0] {
        ST_COLLECT,
        ST_EMIT
    } state_t;

    // control broadcast to every cell
    typedef struct packed {
        logic insert;   // place the incoming value into the sorted row
        logic shift;    // move every entry one cell toward the head
    } cell_ctrl_t;

endpackage

>>> src/integer_array_sorter_unit.sv
// ----------------------------------------------------------------------------
// integer_array_sorter_unit - streaming insertion sorter
// Collects a set of signed values and returns them in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low; it
//   carries value and is_last. Requests may follow every cycle while busy is
//   low: each value is placed into a row of DEPTH cells in the cycle it
//   arrives. The request with is_last high closes the set. busy rises the
//   next cycle and the row drains from its head, one value per cycle;
//   results appear on sorted_value with strobe high for one cycle each,
//   registered from the head cell, end_of_set on the final one. A new
//   request is taken while the final result is shown.
//   Elements beyond DEPTH are dropped; every result of that set then carries
//   overflow. The receiver cannot stall the stream.
//   Reset empties the row and the count; nothing else needs clearing.
// ----------------------------------------------------------------------------
module integer_array_sorter_unit
    import ias_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  data_t value,
    input  logic  is_last,
    output logic  strobe,
    output data_t sorted_value,
    output logic  end_of_set,
    output logic  overflow
);

    cell_ctrl_t ctrl;
    data_t      cell_value [DEPTH];
    logic       cell_valid [DEPTH];
    logic       cell_lt    [DEPTH];

    ias_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .is_last     (is_last),
        .head_value  (cell_value[0]),
        .busy        (busy),
        .ctrl        (ctrl),
        .strobe      (strobe),
        .sorted_value(sorted_value),
        .end_of_set  (end_of_set),
        .overflow    (overflow)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic  left_lt;
        data_t left_value;
        logic  left_valid;
        data_t right_value;
        logic  right_valid;

        if (i == 0)
        begin : g_head
            assign left_lt    = 1'b0;
            assign left_value = '0;
            assign left_valid = 1'b0;
        end
        else
        begin : g_body
            assign left_lt    = cell_lt[i-1];
            assign left_value = cell_value[i-1];
            assign left_valid = cell_valid[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_value = '0;
            assign right_valid = 1'b0;
        end
        else
        begin : g_inner
            assign right_value = cell_value[i+1];
            assign right_valid = cell_valid[i+1];
        end

        ias_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_value  (value),
            .left_lt    (left_lt),
            .left_value (left_value),
            .left_valid (left_valid),
            .right_value(right_value),
            .right_valid(right_valid),
            .value_q    (cell_value[i]),
            .valid_q    (cell_valid[i]),
            .lt         (cell_lt[i])
        );
    end

    a_drain_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.shift |-> cell_valid[0])
        else $error("drain read an empty head cell");

    a_row_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[1] |-> cell_valid[0] && cell_value[0] <= cell_value[1])
        else $error("head of row out of order");

    a_idle_row_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> !cell_valid[0])
        else $error("row not empty after drain");

endmodule

>>> src/ias_cell.sv
// ----------------------------------------------------------------------------
// ias_cell - one slot of the sorted row
// Holds one value and its valid bit. On insert it keeps its value, takes the
// new value, or takes its left neighbor's value; on shift it takes its right
// neighbor's value.
// ----------------------------------------------------------------------------
module ias_cell
    import ias_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  data_t      new_value,
    input  logic       left_lt,
    input  data_t      left_value,
    input  logic       left_valid,
    input  data_t      right_value,
    input  logic       right_valid,
    output data_t      value_q,
    output logic       valid_q,
    output logic       lt
);

    data_t value_reg;
    data_t value_next;
    logic  valid_reg;
    logic  valid_next;

    // the new value belongs before this entry (an empty slot counts as +inf)
    assign lt = !valid_reg || (new_value < value_reg);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.shift)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
        else if (ctrl.insert && lt)
        begin
            if (left_lt)
            begin
                // the new value lands further left: take the neighbor's entry
                value_next = left_value;
                valid_next = left_valid;
            end
            else
            begin
                value_next = new_value;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value_q = value_reg;
    assign valid_q = valid_reg;

endmodule

>>> src/ias_ctrl.sv
// ----------------------------------------------------------------------------
// ias_ctrl - request handshake, element count and result stream
// Counts stored elements, flags dropped ones, and drains the row from its
// head once the final element of a set has been taken.
// ----------------------------------------------------------------------------
module ias_ctrl
    import ias_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       is_last,
    input  data_t      head_value,
    output logic       busy,
    output cell_ctrl_t ctrl,
    output logic       strobe,
    output data_t      sorted_value,
    output logic       end_of_set,
    output logic       overflow
);

    localparam int CntW = $clog2(DEPTH + 1);

    state_t          state_reg;
    state_t          state_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            dropped_reg;
    logic            dropped_next;
    logic            strobe_reg;
    data_t           sorted_value_reg;
    logic            end_of_set_reg;
    logic            overflow_reg;

    logic accept;
    logic full;

    assign full   = (count_reg == CntW'(DEPTH));
    assign accept = start && !busy;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (accept && is_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (count_reg == CntW'(1))
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // outputs and counters
    always_comb
    begin
        busy         = 1'b0;
        ctrl.insert  = 1'b0;
        ctrl.shift   = 1'b0;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + CntW'(1);
                    end
                end
            end
            ST_EMIT:
            begin
                busy       = 1'b1;
                ctrl.shift = 1'b1;
                count_next = count_reg - CntW'(1);
                // drop the overflow mark with the last result of the set
                if (count_reg == CntW'(1))
                begin
                    dropped_next = 1'b0;
                end
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_COLLECT;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            strobe_reg  <= (state_reg == ST_EMIT);
        end
    end

    always_ff @(posedge clk)
    begin
        sorted_value_reg <= head_value;
        end_of_set_reg   <= (count_reg == CntW'(1));
        overflow_reg     <= dropped_reg;
    end

    assign strobe       = strobe_reg;
    assign sorted_value = sorted_value_reg;
    assign end_of_set   = end_of_set_reg;
    assign overflow     = overflow_reg;

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> count_reg != '0)
        else $error("emitting with an empty row");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(DEPTH))
        else $error("element count beyond depth");

    a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(state_reg == ST_EMIT))
        else $error("result strobe outside a drain");

    a_last_closes_set: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && count_reg == CntW'(1) |=> state_reg == ST_COLLECT
            && count_reg == '0 && !dropped_reg)
        else $error("set not closed after final result");

endmodule

>>> tb/integer_array_sorter_unit_tb.sv
// ----------------------------------------------------------------------------
// integer_array_sorter_unit_tb - self-checking bench for the insertion sorter
// Sends sets of signed values as requests, partly with random bursts and gaps,
// keeps a software copy of the store to work out each sorted set, and
// compares every strobed result against the oldest pending expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module integer_array_sorter_unit_tb
    import ias_pkg::*;
();

    localparam int DEPTH        = 64;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = DEPTH + 8;
    localparam int RANDOM_ITEMS = 90;

    typedef struct packed {
        data_t sorted_value;
        logic  end_of_set;
        logic  overflow;
    } sorted_result_t;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    data_t value;
    logic  is_last;
    logic  strobe;
    data_t sorted_value;
    logic  end_of_set;
    logic  overflow;

    sorted_result_t pending_results[$];
    sorted_result_t oldest_result;
    data_t          set_store[DEPTH];
    int             set_count;
    logic           set_dropped;
    int             err_count;
    int             idle_cycles;
    int             burst_left;
    bit             gaps_on;

    integer_array_sorter_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .value       (value),
        .is_last     (is_last),
        .strobe      (strobe),
        .sorted_value(sorted_value),
        .end_of_set  (end_of_set),
        .overflow    (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Store one accepted element; on the closing one, sort the set and queue
    // its results. Equal values are indistinguishable, so any sort will do.
    task automatic collect_and_sort(data_t v, logic last);
        int    i;
        int    j;
        data_t key;
        if (set_count < DEPTH)
        begin
            set_store[set_count] = v;
            set_count++;
        end
        else
        begin
            set_dropped = 1'b1;
        end
        if (last)
        begin
            for (i = 1; i < set_count; i++)
            begin
                key = set_store[i];
                j   = i - 1;
                while (j >= 0 && set_store[j] > key)
                begin
                    set_store[j + 1] = set_store[j];
                    j--;
                end
                set_store[j + 1] = key;
            end
            for (i = 0; i < set_count; i++)
                pending_results.push_back('{set_store[i], (i == set_count - 1),
                                            set_dropped});
            set_count   = 0;
            set_dropped = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            collect_and_sort(value, is_last);
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: sorted_value=%0d end_of_set=%0b overflow=%0b",
                       sorted_value, end_of_set, overflow);
                err_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (sorted_value !== oldest_result.sorted_value)
                begin
                    $error("sorted_value: expected %0d, actual %0d",
                           oldest_result.sorted_value, sorted_value);
                    err_count++;
                end
                if (end_of_set !== oldest_result.end_of_set)
                begin
                    $error("end_of_set: expected %0b, actual %0b",
                           oldest_result.end_of_set, end_of_set);
                    err_count++;
                end
                if (overflow !== oldest_result.overflow)
                begin
                    $error("overflow: expected %0b, actual %0b",
                           oldest_result.overflow, overflow);
                    err_count++;
                end
            end
        end
    end

    // Stop the run when neither a request nor a result moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_element(data_t v, logic last);
        int gap;
        start   <= 1'b1;
        value   <= v;
        is_last <= last;
        do
            @(posedge clk);
        while (busy);
        if (burst_left > 0)
            burst_left--;
        if (gaps_on && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                // drive noise on the payload while start is low
                start   <= 1'b0;
                value   <= $urandom;
                is_last <= $urandom_range(0, 1);
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic pause_until_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    function automatic data_t pick_value();
        data_t r;
        case ($urandom_range(0, 3))
            0, 1: r = $urandom;
            2:    r = data_t'($urandom_range(0, 8) - 4);
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       r = 32'sh7FFF_FFFF;
                    1:       r = 32'sh8000_0000;
                    2:       r = '0;
                    default: r = '1;
                endcase
            end
        endcase
        return r;
    endfunction

    task automatic test_single_element_sets();
        // back to back: the second request lands while the first result shows
        send_element(32'sh7FFF_FFFF, 1'b1);
        send_element(32'sh8000_0000, 1'b1);
        send_element(32'sh0000_0000, 1'b1);
        pause_until_drained();
    endtask

    task automatic test_extreme_values();
        send_element(32'sh7FFF_FFFF, 1'b0);
        send_element(32'sh8000_0000, 1'b0);
        send_element(32'sh0000_0000, 1'b0);
        send_element(32'shFFFF_FFFF, 1'b0);
        send_element(32'sh0000_0001, 1'b0);
        send_element(32'sh8000_0000, 1'b0);
        send_element(32'sh7FFF_FFFF, 1'b0);
        send_element(32'sh5555_5555, 1'b0);
        send_element(32'shAAAA_AAAA, 1'b1);
        pause_until_drained();
    endtask

    task automatic test_ordered_runs();
        int i;
        for (i = 4; i >= 1; i--)
            send_element(data_t'(i), 1'b0);
        for (i = 1; i <= 4; i++)
            send_element(data_t'(-i), (i == 4));
    endtask

    task automatic test_store_overflow();
        int i;
        // the closing element is past the store depth and is dropped too
        for (i = 0; i < DEPTH + 2; i++)
            send_element(pick_value(), (i == DEPTH + 1));
        pause_until_drained();
    endtask

    task automatic test_random_sets(int items);
        int sent;
        int set_size;
        int i;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(0, 9) == 0)
                set_size = $urandom_range(DEPTH - 2, DEPTH + 3);
            else
                set_size = $urandom_range(1, 10);
            for (i = 0; i < set_size; i++)
                send_element(pick_value(), (i == set_size - 1));
            sent += set_size;
            if ($urandom_range(0, 3) == 0)
                pause_until_drained();
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        value       = '0;
        is_last     = 1'b0;
        set_count   = 0;
        set_dropped = 1'b0;
        err_count   = 0;
        idle_cycles = 0;
        burst_left  = 0;
        gaps_on     = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_element_sets();
        gaps_on = 1'b1;
        test_extreme_values();
        test_ordered_runs();
        test_store_overflow();
        gaps_on = 1'b0;
        test_random_sets(RANDOM_ITEMS / 3);
        gaps_on = 1'b1;
        test_random_sets(RANDOM_ITEMS - RANDOM_ITEMS / 3);

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            err_count++;
        end
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
